FILE: rtl/core/pde_pkg.sv
// Shared constants, request codes and index helpers for the pedigree dominance block.
// Used by pedigree_dominance_entry_top; depends on nothing else.
package pde_pkg;

  // Store geometry.
  localparam int MAX_ANIMALS = 256;
  localparam int ANI_W       = (MAX_ANIMALS > 1) ? $clog2(MAX_ANIMALS) : 1;
  localparam int REL_DEPTH   = MAX_ANIMALS * MAX_ANIMALS;
  localparam int REL_AW      = $clog2(REL_DEPTH);

  // Field widths fixed by the interface.
  localparam int REQ_W = 2;
  localparam int IDX_W = 8;
  localparam int VAL_W = 16;
  localparam int PAR_W = 9;
  localparam int PRD_W = 2 * VAL_W;

  // Parent store holds the sire number above the dam number.
  localparam int PST_W = 2 * PAR_W;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_REL_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PAR_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd2;

  // Q2.14 constants.
  localparam logic [VAL_W-1:0] ONE_Q14 = 16'd16384;
  localparam logic [VAL_W-1:0] VAL_MAX = 16'hFFFF;

  // An animal index names a stored animal.
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return int'(idx) < MAX_ANIMALS;
  endfunction

  // A parent number names a known animal: nonzero and within the store.
  function automatic logic parent_ok(input logic [PAR_W-1:0] num);
    return (num != '0) && ((int'(num) - 1) < MAX_ANIMALS);
  endfunction

  // Parent number to animal index.
  function automatic logic [ANI_W-1:0] parent_idx(input logic [PAR_W-1:0] num);
    return ANI_W'(int'(num) - 1);
  endfunction

  // Port index to store index.
  function automatic logic [ANI_W-1:0] to_ani(input logic [IDX_W-1:0] idx);
    return ANI_W'(int'(idx));
  endfunction

  // Row-major address of relationship entry (r, c).
  function automatic logic [REL_AW-1:0] rel_addr(input logic [ANI_W-1:0] r,
                                                 input logic [ANI_W-1:0] c);
    return REL_AW'(int'(r) * MAX_ANIMALS + int'(c));
  endfunction

endpackage

FILE: rtl/core/pde_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Stand-alone; used for the relationship and parent stores.
module pde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the addressed entry when enabled; its old contents are read out through a register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/pedigree_dominance_entry_top.sv
// Top level of the pedigree dominance entry block: sequencer, multipliers and two stores.
// Depends on pde_pkg and pde_ram.
//
//   channel   ports                                   handshake
//   input     in_req_type, in_index_a/b, in_rel_value,
//             in_sire_number, in_dam_number            start, busy
//   result    out_dominance_value, out_row_echo/col    out_valid (one-cycle strobe)
//
// A write completes at acceptance. A query passes from acceptance to the strobe through
// two parent reads and four relationship reads on single-port RAMs with registered read
// ports, followed by the second product and the final sum. A diagonal query goes straight
// to the final state; one with an unknown parent or index leaves the reads after ST_REL0.
// Reset clears the sequencer and the strobe only; the stores hold garbage until written.
// The receiver cannot stall; a new transaction is accepted in the strobe cycle.
module pedigree_dominance_entry_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pde_pkg::REQ_W-1:0]     in_req_type,
  input  logic [pde_pkg::IDX_W-1:0]     in_index_a,
  input  logic [pde_pkg::IDX_W-1:0]     in_index_b,
  input  logic [pde_pkg::VAL_W-1:0]     in_rel_value,
  input  logic [pde_pkg::PAR_W-1:0]     in_sire_number,
  input  logic [pde_pkg::PAR_W-1:0]     in_dam_number,
  output logic                          out_valid,
  output logic [pde_pkg::VAL_W-1:0]     out_dominance_value,
  output logic [pde_pkg::IDX_W-1:0]     out_row_echo,
  output logic [pde_pkg::IDX_W-1:0]     out_col_echo
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAR_J = 3'd1;
  localparam logic [2:0] ST_REL0  = 3'd2;
  localparam logic [2:0] ST_REL1  = 3'd3;
  localparam logic [2:0] ST_REL2  = 3'd4;
  localparam logic [2:0] ST_REL3  = 3'd5;
  localparam logic [2:0] ST_MUL1  = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;

  logic accept;

  // Query registers.
  logic [pde_pkg::IDX_W-1:0] row_r, col_r;
  logic                      row_ok_r, col_ok_r;
  logic                      diag_r, zero_r;
  logic [pde_pkg::ANI_W-1:0] si_r, di_r, sj_r, dj_r;
  logic                      ksi_r, kdi_r;
  logic [pde_pkg::VAL_W-1:0] op_r;
  logic [pde_pkg::PRD_W-1:0] prod0_r, prod1_r;

  // Output registers.
  logic                      out_valid_r;
  logic [pde_pkg::VAL_W-1:0] out_val_r;
  logic [pde_pkg::IDX_W-1:0] out_row_r, out_col_r;

  // Store ports.
  logic                       par_we;
  logic [pde_pkg::ANI_W-1:0]  par_addr;
  logic [pde_pkg::PST_W-1:0]  par_wdata, par_rdata;
  logic                       rel_we;
  logic [pde_pkg::REL_AW-1:0] rel_addr;
  logic [pde_pkg::VAL_W-1:0]  rel_rdata;

  // Decoded parents of the row or the column animal, straight from the parent store.
  logic [pde_pkg::PAR_W-1:0] sire_rd, dam_rd;
  logic                      all_known;

  // Final sum and saturation.
  logic [pde_pkg::PRD_W:0]   sum;
  logic [pde_pkg::PRD_W-pde_pkg::VAL_W:0] quot;
  logic [pde_pkg::VAL_W-1:0] sat_val;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign sire_rd = par_rdata[pde_pkg::PST_W-1:pde_pkg::PAR_W];
  assign dam_rd  = par_rdata[pde_pkg::PAR_W-1:0];

  // Both product terms need both indices in range and all four parents known.
  assign all_known = row_ok_r && col_ok_r && ksi_r && kdi_r &&
                     pde_pkg::parent_ok(sire_rd) && pde_pkg::parent_ok(dam_rd);

  // Parent store: written by parent writes, read for the row then the column animal.
  assign par_we    = accept && (in_req_type == pde_pkg::REQ_PAR_WRITE) &&
                     pde_pkg::idx_ok(in_index_a);
  assign par_wdata = {in_sire_number, in_dam_number};
  assign par_addr  = busy ? pde_pkg::to_ani(col_r) : pde_pkg::to_ani(in_index_a);

  // Relationship store: one write port address, or one of the four product operands.
  assign rel_we = accept && (in_req_type == pde_pkg::REQ_REL_WRITE) &&
                  pde_pkg::idx_ok(in_index_a) && pde_pkg::idx_ok(in_index_b);

  always_comb begin
    unique case (state_r)
      ST_REL0: rel_addr = pde_pkg::rel_addr(si_r, pde_pkg::parent_idx(sire_rd));
      ST_REL1: rel_addr = pde_pkg::rel_addr(di_r, dj_r);
      ST_REL2: rel_addr = pde_pkg::rel_addr(si_r, dj_r);
      ST_REL3: rel_addr = pde_pkg::rel_addr(sj_r, di_r);
      default: rel_addr = pde_pkg::rel_addr(pde_pkg::to_ani(in_index_a),
                                            pde_pkg::to_ani(in_index_b));
    endcase
  end

  pde_ram #(
    .WIDTH (pde_pkg::PST_W),
    .DEPTH (pde_pkg::MAX_ANIMALS)
  ) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .addr  (par_addr),
    .wdata (par_wdata),
    .rdata (par_rdata)
  );

  pde_ram #(
    .WIDTH (pde_pkg::VAL_W),
    .DEPTH (pde_pkg::REL_DEPTH)
  ) u_rel_ram (
    .clk   (clk),
    .we    (rel_we),
    .addr  (rel_addr),
    .wdata (in_rel_value),
    .rdata (rel_rdata)
  );

  // Next-state logic of the query sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == pde_pkg::REQ_QUERY)) begin
          state_nxt = (in_index_a == in_index_b) ? ST_FIN : ST_PAR_J;
        end
      end
      ST_PAR_J: state_nxt = ST_REL0;
      ST_REL0:  state_nxt = all_known ? ST_REL1 : ST_FIN;
      ST_REL1:  state_nxt = ST_REL2;
      ST_REL2:  state_nxt = ST_REL3;
      ST_REL3:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_FIN);
    end
  end

  // Payload registers along the query.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r    <= in_index_a;
      col_r    <= in_index_b;
      row_ok_r <= pde_pkg::idx_ok(in_index_a);
      col_ok_r <= pde_pkg::idx_ok(in_index_b);
      diag_r   <= (in_index_a == in_index_b);
      zero_r   <= 1'b0;
    end
    if (state_r == ST_PAR_J) begin
      si_r  <= pde_pkg::parent_idx(sire_rd);
      di_r  <= pde_pkg::parent_idx(dam_rd);
      ksi_r <= pde_pkg::parent_ok(sire_rd);
      kdi_r <= pde_pkg::parent_ok(dam_rd);
    end
    if (state_r == ST_REL0) begin
      sj_r   <= pde_pkg::parent_idx(sire_rd);
      dj_r   <= pde_pkg::parent_idx(dam_rd);
      zero_r <= !all_known;
    end
    if (state_r == ST_REL1 || state_r == ST_REL3) begin
      op_r <= rel_rdata;
    end
    if (state_r == ST_REL2) begin
      prod0_r <= op_r * rel_rdata;
    end
    if (state_r == ST_MUL1) begin
      prod1_r <= op_r * rel_rdata;
    end
  end

  // Quarter of the product sum back to Q2.14, saturated.
  assign sum     = {1'b0, prod0_r} + {1'b0, prod1_r};
  assign quot    = sum[pde_pkg::PRD_W:pde_pkg::VAL_W];
  assign sat_val = quot[pde_pkg::PRD_W-pde_pkg::VAL_W] ? pde_pkg::VAL_MAX
                                                       : quot[pde_pkg::VAL_W-1:0];

  // Result registers, loaded as the sequencer leaves its final state.
  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_row_r <= row_r;
      out_col_r <= col_r;
      if (diag_r) begin
        out_val_r <= pde_pkg::ONE_Q14;
      end else if (zero_r) begin
        out_val_r <= '0;
      end else begin
        out_val_r <= sat_val;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dominance_value = out_val_r;
  assign out_row_echo        = out_row_r;
  assign out_col_echo        = out_col_r;

  // An accepted query keeps the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == pde_pkg::REQ_QUERY)) |=> busy)
    else $error("query transaction did not occupy the sequencer");

  // A transaction other than a query never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type != pde_pkg::REQ_QUERY)) |=> !out_valid)
    else $error("result strobe after a write transaction");

  // A strobe only follows the final sequencer state.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_FIN))
    else $error("result strobe without a finished query");

  // Diagonal entries are always one.
  a_diag_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_row_echo == out_col_echo)) |->
      (out_dominance_value == pde_pkg::ONE_Q14))
    else $error("diagonal dominance entry is not one");

endmodule

FILE: sim/tb_top.sv
// Testbench for pedigree_dominance_entry_top: a directed table of transactions, then random
// pedigree scenarios, checked against table values or a bench predictor. Depends on pde_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pde_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1450;
  localparam int PHASE_ITEMS  = 240;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_SHOWN    = 10;
  localparam int PAR_TOP      = (1 << pde_pkg::PAR_W) - 1;

  // One input transaction; typed rows carry their expected dominance value.
  typedef struct {
    logic [pde_pkg::REQ_W-1:0] kind;
    logic [pde_pkg::IDX_W-1:0] a;
    logic [pde_pkg::IDX_W-1:0] b;
    logic [pde_pkg::VAL_W-1:0] val;
    logic [pde_pkg::PAR_W-1:0] sire;
    logic [pde_pkg::PAR_W-1:0] dam;
    bit                        typed;
    logic [pde_pkg::VAL_W-1:0] want;
  } txn_t;

  typedef struct {
    logic [pde_pkg::VAL_W-1:0] dom;
    logic [pde_pkg::IDX_W-1:0] row;
    logic [pde_pkg::IDX_W-1:0] col;
  } dom_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [pde_pkg::REQ_W-1:0] in_req_type = '0;
  logic [pde_pkg::IDX_W-1:0] in_index_a = '0;
  logic [pde_pkg::IDX_W-1:0] in_index_b = '0;
  logic [pde_pkg::VAL_W-1:0] in_rel_value = '0;
  logic [pde_pkg::PAR_W-1:0] in_sire_number = '0;
  logic [pde_pkg::PAR_W-1:0] in_dam_number = '0;
  logic                      out_valid;
  logic [pde_pkg::VAL_W-1:0] out_dominance_value;
  logic [pde_pkg::IDX_W-1:0] out_row_echo;
  logic [pde_pkg::IDX_W-1:0] out_col_echo;

  // Predicted contents of the stores, and which entries have been written.
  logic [pde_pkg::VAL_W-1:0] rel_mem [pde_pkg::REL_DEPTH];
  logic [pde_pkg::PAR_W-1:0] sire_mem [pde_pkg::MAX_ANIMALS];
  logic [pde_pkg::PAR_W-1:0] dam_mem [pde_pkg::MAX_ANIMALS];
  bit                        rel_seen [pde_pkg::REL_DEPTH];
  bit                        par_seen [pde_pkg::MAX_ANIMALS];

  dom_result_t               pending_dom_q [$];
  logic [pde_pkg::IDX_W-1:0] herd [$];
  int                        mismatches = 0;
  int                        burst_left = 0;
  int                        items_done = 0;

  always #10 clk = ~clk;

  pedigree_dominance_entry_top i_dut (.*);

  function automatic txn_t txn(input logic [pde_pkg::REQ_W-1:0] kind,
                               input logic [pde_pkg::IDX_W-1:0] a,
                               input logic [pde_pkg::IDX_W-1:0] b,
                               input logic [pde_pkg::VAL_W-1:0] val,
                               input logic [pde_pkg::PAR_W-1:0] sire,
                               input logic [pde_pkg::PAR_W-1:0] dam,
                               input bit typed = 1'b0,
                               input logic [pde_pkg::VAL_W-1:0] want = '0);
    txn_t t;
    t.kind = kind;
    t.a = a;
    t.b = b;
    t.val = val;
    t.sire = sire;
    t.dam = dam;
    t.typed = typed;
    t.want = want;
    return t;
  endfunction

  // A parent number names an animal when it is nonzero and inside the store.
  function automatic bit parent_known(input logic [pde_pkg::PAR_W-1:0] num);
    return (num != '0) && (int'(num) <= pde_pkg::MAX_ANIMALS);
  endfunction

  function automatic logic [pde_pkg::VAL_W-1:0] rel_at(input logic [pde_pkg::PAR_W-1:0] r_num,
                                                       input logic [pde_pkg::PAR_W-1:0] c_num);
    return rel_mem[(int'(r_num) - 1) * pde_pkg::MAX_ANIMALS + int'(c_num) - 1];
  endfunction

  // Dominance entry of the pair (i, j) from the predicted store contents.
  function automatic logic [pde_pkg::VAL_W-1:0] dominance_of(
      input logic [pde_pkg::IDX_W-1:0] i, input logic [pde_pkg::IDX_W-1:0] j);
    logic [pde_pkg::PAR_W-1:0]   s_i, d_i, s_j, d_j;
    logic [2*pde_pkg::VAL_W:0]   acc;
    logic [pde_pkg::VAL_W:0]     quarter;
    if (i == j) return pde_pkg::ONE_Q14;
    s_i = '0;
    d_i = '0;
    s_j = '0;
    d_j = '0;
    if (int'(i) < pde_pkg::MAX_ANIMALS) begin
      s_i = sire_mem[i];
      d_i = dam_mem[i];
    end
    if (int'(j) < pde_pkg::MAX_ANIMALS) begin
      s_j = sire_mem[j];
      d_j = dam_mem[j];
    end
    acc = '0;
    // Both terms use all four parents, so either both count or neither does.
    if (parent_known(s_i) && parent_known(d_i) && parent_known(s_j) && parent_known(d_j)) begin
      acc = rel_at(s_i, s_j) * rel_at(d_i, d_j) + rel_at(s_i, d_j) * rel_at(s_j, d_i);
    end
    quarter = acc[2*pde_pkg::VAL_W:pde_pkg::VAL_W];
    if (quarter > pde_pkg::VAL_MAX) return pde_pkg::VAL_MAX;
    return quarter[pde_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [pde_pkg::IDX_W-1:0] herd_member();
    return herd[$urandom_range(0, herd.size() - 1)];
  endfunction

  // Parents mostly come from the herd, with some unknown and out-of-range numbers.
  function automatic logic [pde_pkg::PAR_W-1:0] pick_parent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return pde_pkg::PAR_W'(herd_member()) + pde_pkg::PAR_W'(1);
    if (r < 80) return '0;
    if (r < 86) return pde_pkg::PAR_W'(pde_pkg::MAX_ANIMALS);
    if (r < 94) return pde_pkg::PAR_W'($urandom_range(pde_pkg::MAX_ANIMALS + 1, PAR_TOP));
    return pde_pkg::PAR_W'($urandom_range(1, pde_pkg::MAX_ANIMALS));
  endfunction

  function automatic logic [pde_pkg::VAL_W-1:0] pick_rel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return pde_pkg::VAL_W'($urandom);
    if (r < 45) return '0;
    if (r < 55) return pde_pkg::VAL_MAX;
    if (r < 65) return pde_pkg::ONE_Q14;
    return pde_pkg::VAL_W'($urandom_range(0, 2 * int'(pde_pkg::ONE_Q14)));
  endfunction

  function automatic void new_herd();
    herd.delete();
    repeat ($urandom_range(4, 16)) herd.push_back(pde_pkg::IDX_W'($urandom));
  endfunction

  // Drive one transaction in bursts with random gaps, wait for acceptance and predict it.
  task automatic send_txn(input txn_t t);
    bit          taken;
    int          addr;
    dom_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_req_type <= t.kind;
    in_index_a <= t.a;
    in_index_b <= t.b;
    in_rel_value <= t.val;
    in_sire_number <= t.sire;
    in_dam_number <= t.dam;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    addr = int'(t.a) * pde_pkg::MAX_ANIMALS + int'(t.b);
    case (t.kind)
      pde_pkg::REQ_REL_WRITE: begin
        if (int'(t.a) < pde_pkg::MAX_ANIMALS && int'(t.b) < pde_pkg::MAX_ANIMALS) begin
          rel_mem[addr] = t.val;
          rel_seen[addr] = 1'b1;
        end
      end
      pde_pkg::REQ_PAR_WRITE: begin
        if (int'(t.a) < pde_pkg::MAX_ANIMALS) begin
          sire_mem[t.a] = t.sire;
          dam_mem[t.a] = t.dam;
          par_seen[t.a] = 1'b1;
        end
      end
      pde_pkg::REQ_QUERY: begin
        res.dom = t.typed ? t.want : dominance_of(t.a, t.b);
        res.row = t.a;
        res.col = t.b;
        pending_dom_q.push_back(res);
      end
      default: ;
    endcase
    if (t.kind != REQ_UNUSED) items_done++;
    @(negedge clk);
  endtask

  // Hold the sender off until every expected result is in, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_dom_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One well-formed query: make sure every store entry it reads is written, ask, then maybe add noise.
  task automatic pedigree_scenario();
    logic [pde_pkg::IDX_W-1:0] i, j;
    logic [pde_pkg::PAR_W-1:0] rr [4];
    logic [pde_pkg::PAR_W-1:0] cc [4];
    int                        addr;
    i = herd_member();
    j = ($urandom_range(0, 9) == 0) ? i : herd_member();
    if (!par_seen[i] || $urandom_range(0, 4) == 0) begin
      send_txn(txn(pde_pkg::REQ_PAR_WRITE, i, pde_pkg::IDX_W'($urandom),
                   pde_pkg::VAL_W'($urandom), pick_parent(), pick_parent()));
    end
    if (!par_seen[j] || $urandom_range(0, 4) == 0) begin
      send_txn(txn(pde_pkg::REQ_PAR_WRITE, j, pde_pkg::IDX_W'($urandom),
                   pde_pkg::VAL_W'($urandom), pick_parent(), pick_parent()));
    end
    if (i != j && parent_known(sire_mem[i]) && parent_known(dam_mem[i]) &&
        parent_known(sire_mem[j]) && parent_known(dam_mem[j])) begin
      rr[0] = sire_mem[i]; cc[0] = sire_mem[j];
      rr[1] = dam_mem[i];  cc[1] = dam_mem[j];
      rr[2] = sire_mem[i]; cc[2] = dam_mem[j];
      rr[3] = sire_mem[j]; cc[3] = dam_mem[i];
      for (int k = 0; k < 4; k++) begin
        addr = (int'(rr[k]) - 1) * pde_pkg::MAX_ANIMALS + int'(cc[k]) - 1;
        if (!rel_seen[addr] || $urandom_range(0, 6) == 0) begin
          send_txn(txn(pde_pkg::REQ_REL_WRITE, pde_pkg::IDX_W'(int'(rr[k]) - 1),
                       pde_pkg::IDX_W'(int'(cc[k]) - 1), pick_rel(),
                       pde_pkg::PAR_W'($urandom), pde_pkg::PAR_W'($urandom)));
        end
      end
    end
    send_txn(txn(pde_pkg::REQ_QUERY, i, j, pde_pkg::VAL_W'($urandom),
                 pde_pkg::PAR_W'($urandom), pde_pkg::PAR_W'($urandom)));
    // Occasional noise between queries.
    case ($urandom_range(0, 11))
      0: send_txn(txn(REQ_UNUSED, pde_pkg::IDX_W'($urandom), pde_pkg::IDX_W'($urandom),
                      pde_pkg::VAL_W'($urandom), pde_pkg::PAR_W'($urandom),
                      pde_pkg::PAR_W'($urandom)));
      1: send_txn(txn(pde_pkg::REQ_REL_WRITE, pde_pkg::IDX_W'($urandom),
                      pde_pkg::IDX_W'($urandom), pde_pkg::VAL_W'($urandom),
                      pde_pkg::PAR_W'($urandom), pde_pkg::PAR_W'($urandom)));
      2: send_txn(txn(pde_pkg::REQ_PAR_WRITE, herd_member(), pde_pkg::IDX_W'($urandom),
                      pde_pkg::VAL_W'($urandom), pde_pkg::PAR_W'($urandom),
                      pde_pkg::PAR_W'($urandom)));
      default: ;
    endcase
  endtask

  // Compare each result strobe with the oldest expectation.
  always @(posedge clk) begin : check_results
    dom_result_t e;
    if (rst_n && out_valid) begin
      if (pending_dom_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected result: dom=%0d row=%0d col=%0d",
                   out_dominance_value, out_row_echo, out_col_echo);
        end
      end else begin
        e = pending_dom_q.pop_front();
        if (out_dominance_value !== e.dom || out_row_echo !== e.row ||
            out_col_echo !== e.col) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: expected dom=%0d row=%0d col=%0d, got dom=%0d row=%0d col=%0d",
                     e.dom, e.row, e.col, out_dominance_value, out_row_echo, out_col_echo);
          end
        end
      end
    end
  end

  initial begin : main_seq
    txn_t dir_rows [$];
    int   next_phase;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table. Animal 0 has unknown parents, 255 has both parents 255,
    // 1 has parents (0, 1), 2 has (255, 0), and 3 has an out-of-range sire.
    dir_rows.push_back(txn(pde_pkg::REQ_PAR_WRITE, 8'd0, 8'd0, 16'd0, 9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_PAR_WRITE, 8'd255, 8'd255, 16'd0, 9'd256, 9'd256));
    dir_rows.push_back(txn(pde_pkg::REQ_PAR_WRITE, 8'd1, 8'd0, 16'd0, 9'd1, 9'd2));
    dir_rows.push_back(txn(pde_pkg::REQ_PAR_WRITE, 8'd2, 8'd0, 16'd0, 9'd256, 9'd1));
    dir_rows.push_back(txn(pde_pkg::REQ_PAR_WRITE, 8'd3, 8'd0, 16'd0, 9'd511, 9'd1));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd0, 8'd0, 16'd0, 9'd0, 9'd0,
                           1'b1, pde_pkg::ONE_Q14));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd255, 8'd255, 16'hFFFF, 9'd511, 9'd511,
                           1'b1, pde_pkg::ONE_Q14));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd0, 8'd1, 16'd0, 9'd0, 9'd0, 1'b1, 16'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd3, 8'd1, 16'd0, 9'd0, 9'd0, 1'b1, 16'd0));
    dir_rows.push_back(txn(REQ_UNUSED, 8'd255, 8'd255, 16'hFFFF, 9'd511, 9'd511));
    // Fill the four entries that query (1, 2) reads at full scale: the sum saturates.
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd0, 8'd255, pde_pkg::VAL_MAX,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd1, 8'd0, pde_pkg::VAL_MAX,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd0, 8'd0, pde_pkg::VAL_MAX,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd255, 8'd1, pde_pkg::VAL_MAX,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd1, 8'd2, 16'd0, 9'd0, 9'd0,
                           1'b1, pde_pkg::VAL_MAX));
    // One term zeroed, then all four entries at 1.0.
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd1, 8'd0, 16'd0, 9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd1, 8'd2, 16'd0, 9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd0, 8'd0, pde_pkg::ONE_Q14,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd255, 8'd1, pde_pkg::ONE_Q14,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd1, 8'd0, pde_pkg::ONE_Q14,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_REL_WRITE, 8'd0, 8'd255, pde_pkg::ONE_Q14,
                           9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd1, 8'd2, 16'd0, 9'd0, 9'd0));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd1, 8'd1, 16'd0, 9'd0, 9'd0,
                           1'b1, pde_pkg::ONE_Q14));
    dir_rows.push_back(txn(pde_pkg::REQ_QUERY, 8'd255, 8'd0, 16'd0, 9'd0, 9'd0,
                           1'b1, 16'd0));
    foreach (dir_rows[n]) send_txn(dir_rows[n]);
    drain();

    // Random pedigree scenarios over a changing herd, pausing between phases.
    items_done = 0;
    next_phase = PHASE_ITEMS;
    new_herd();
    while (items_done < RANDOM_ITEMS) begin
      pedigree_scenario();
      if (items_done >= next_phase) begin
        drain();
        new_herd();
        next_phase += PHASE_ITEMS;
      end
    end
    drain();

    if (mismatches == 0 && pending_dom_q.size() == 0) begin
      $display("PASS pedigree_dominance_entry_top");
    end else begin
      $display("FAIL pedigree_dominance_entry_top");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("FAIL pedigree_dominance_entry_top");
    $finish;
  end

endmodule

FILE: pedigree_dominance_entry_top.f
rtl/core/pde_pkg.sv
rtl/core/pde_ram.sv
rtl/core/pedigree_dominance_entry_top.sv
sim/tb_top.sv
